// File: hdl/elpd_pkg.sv
// Shared types and constants for the escaped, length-prefixed deframer.
// No dependencies; imported by escaped_length_prefixed_deframer.
package elpd_pkg;

   localparam logic [7:0]  START_DELIM = 8'h7E;
   localparam logic [7:0]  ESCAPE_BYTE = 8'h7D;
   localparam logic [7:0]  XON_BYTE    = 8'h11;
   localparam logic [7:0]  XOFF_BYTE   = 8'h13;
   localparam logic [7:0]  ESC_XOR     = 8'h20;

   localparam int          COUNT_W     = 17;
   localparam logic [16:0] COUNT_MAX   = 17'h1FFFF;

   // what a result beat carries
   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,   // frame byte
      KIND_DONE  = 2'd1,   // byte completing the frame
      KIND_CUT   = 2'd2,   // frame cut by a delimiter
      KIND_ABORT = 2'd3    // frame aborted by a bad escape
   } kind_type;

   typedef struct packed {
      logic       last_of_run;
      logic       first_of_frame;
      kind_type   kind;
      logic [7:0] out_byte;
   } rsp_item_type;

endpackage

// File: hdl/escaped_length_prefixed_deframer.sv
// Receive deframer for byte-stuffed, length-prefixed link frames.
// Depends on elpd_pkg (constants, kind codes, result item struct).

// One raw link byte is taken per req beat. Outside a frame, bytes are dropped
// until 0x7E, which opens a frame and comes out flagged first_of_frame. Inside
// a frame 0x7D escapes the next byte, which must be 0x5E, 0x5D, 0x31 or 0x33
// and comes out XOR 0x20; anything else aborts the frame (kind 3). An
// unescaped 0x7E inside a frame gives two beats: a cut marker (kind 2) and the
// delimiter opening the new frame. Frame bytes 1 and 2 carry a big-endian
// length; the byte bringing the count to length+4 is flagged kind 1 and ends
// the frame. A zero length never completes; the count saturates. The checksum
// is not checked. Rate: one input byte per cycle while req_tready is high. The
// state update is done in the same cycle the byte is taken, and its results
// are registered into a four-entry result queue whose head drives rsp;
// req_tready stays high while the queue has room for two beats. With rsp_tready
// high the block takes a byte every cycle, except that each delimiter inside a
// frame adds a second beat, so a run of them fills the queue and stalls req.
module escaped_length_prefixed_deframer
   import elpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] in_byte

   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_byte
   output logic [2:0] rsp_tuser,    // [1:0] kind, [2] first_of_frame
   output logic       rsp_tlast     // last_of_run
);

   localparam int QDEPTH = 4;
   localparam int PTR_W  = $clog2(QDEPTH);
   localparam int CNT_W  = $clog2(QDEPTH + 1);

   // ---------------- frame state ----------------
   logic               in_frame_ff,     in_frame_in;
   logic               esc_pending_ff,  esc_pending_in;
   logic [COUNT_W-1:0] byte_count_ff,   byte_count_in;
   logic [7:0]         length_high_ff,  length_high_in;
   logic [15:0]        frame_length_ff, frame_length_in;

   // ---------------- result queue ----------------
   rsp_item_type       queue_ff [QDEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff,   fill_in;

   logic               req_beat;
   logic               rsp_beat;
   logic [1:0]         n_push;
   rsp_item_type       res0, res1;

   // room for the worst case of two results per byte
   assign req_tready = (fill_ff <= CNT_W'(QDEPTH - 2));
   assign req_beat   = req_tvalid & req_tready;
   assign rsp_beat   = rsp_tvalid & rsp_tready;

   // decode of one byte against the current frame state
   always_comb begin
      logic [7:0]         b;
      logic [COUNT_W-1:0] cnt;
      logic [15:0]        flen;
      logic [COUNT_W-1:0] size;
      logic               esc_ok;

      b    = req_tdata;
      cnt  = '0;
      flen = '0;
      size = '0;

      in_frame_in     = in_frame_ff;
      esc_pending_in  = esc_pending_ff;
      byte_count_in   = byte_count_ff;
      length_high_in  = length_high_ff;
      frame_length_in = frame_length_ff;

      n_push = 2'd0;
      res0   = '{last_of_run: 1'b1, first_of_frame: 1'b0, kind: KIND_DATA, out_byte: b};
      res1   = '{last_of_run: 1'b1, first_of_frame: 1'b1, kind: KIND_DATA,
                 out_byte: START_DELIM};

      esc_ok = (b == (START_DELIM ^ ESC_XOR)) || (b == (ESCAPE_BYTE ^ ESC_XOR)) ||
               (b == (XON_BYTE ^ ESC_XOR))    || (b == (XOFF_BYTE ^ ESC_XOR));

      if (req_beat) begin
         if (!in_frame_ff) begin
            // hunting: only the delimiter opens a frame
            if (b == START_DELIM) begin
               in_frame_in     = 1'b1;
               esc_pending_in  = 1'b0;
               frame_length_in = '0;
               byte_count_in   = COUNT_W'(1);
               res0.first_of_frame = 1'b1;
               n_push = 2'd1;
            end
         end else if (esc_pending_ff && !esc_ok) begin
            // bad escape drops the frame
            in_frame_in     = 1'b0;
            esc_pending_in  = 1'b0;
            byte_count_in   = '0;
            frame_length_in = '0;
            res0.kind       = KIND_ABORT;
            res0.out_byte   = '0;
            n_push = 2'd1;
         end else if (!esc_pending_ff && b == ESCAPE_BYTE) begin
            esc_pending_in = 1'b1;
         end else if (!esc_pending_ff && b == START_DELIM) begin
            // cut marker, then the delimiter of the next frame
            esc_pending_in  = 1'b0;
            frame_length_in = '0;
            byte_count_in   = COUNT_W'(1);
            res0.kind        = KIND_CUT;
            res0.out_byte    = '0;
            res0.last_of_run = 1'b0;
            n_push = 2'd2;
         end else begin
            // plain or escaped frame byte
            if (esc_pending_ff) begin
               b = b ^ ESC_XOR;
            end
            esc_pending_in = 1'b0;
            cnt = (byte_count_ff == COUNT_MAX) ? byte_count_ff
                                                : byte_count_ff + COUNT_W'(1);
            if (cnt == COUNT_W'(2)) begin
               length_high_in = b;
            end
            flen = frame_length_ff;
            if (frame_length_ff == '0 && cnt == COUNT_W'(3)) begin
               flen = {length_high_ff, b};
            end
            size = {1'b0, flen} + COUNT_W'(4);
            res0.out_byte = b;
            if (flen != '0 && cnt >= size) begin
               res0.kind       = KIND_DONE;
               in_frame_in     = 1'b0;
               byte_count_in   = '0;
               frame_length_in = '0;
            end else begin
               byte_count_in   = cnt;
               frame_length_in = flen;
            end
            n_push = 2'd1;
         end
      end
   end

   // queue pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
      rd_ptr_in = rsp_beat ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + CNT_W'(n_push) - CNT_W'(rsp_beat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff     <= 1'b0;
         esc_pending_ff  <= 1'b0;
         byte_count_ff   <= '0;
         frame_length_ff <= '0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         fill_ff         <= '0;
      end else begin
         in_frame_ff     <= in_frame_in;
         esc_pending_ff  <= esc_pending_in;
         byte_count_ff   <= byte_count_in;
         frame_length_ff <= frame_length_in;
         wr_ptr_ff       <= wr_ptr_in;
         rd_ptr_ff       <= rd_ptr_in;
         fill_ff         <= fill_in;
      end
   end

   // payload storage, no reset needed
   always_ff @(posedge clock) begin
      length_high_ff <= length_high_in;
      for (int i = 0; i < QDEPTH; i++) begin
         if (n_push != 2'd0 && wr_ptr_ff == PTR_W'(i)) begin
            queue_ff[i] <= res0;
         end
         if (n_push == 2'd2 && (wr_ptr_ff + PTR_W'(1)) == PTR_W'(i)) begin
            queue_ff[i] <= res1;
         end
      end
   end

   // head of the queue drives the result beat
   assign rsp_tvalid = (fill_ff != '0);
   assign rsp_tdata  = queue_ff[rd_ptr_ff].out_byte;
   assign rsp_tuser  = {queue_ff[rd_ptr_ff].first_of_frame, queue_ff[rd_ptr_ff].kind};
   assign rsp_tlast  = queue_ff[rd_ptr_ff].last_of_run;

   // ---------------- assertions ----------------
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(QDEPTH))
      else $error("result queue overfilled");

   a_esc_in_frame : assert property (@(posedge clock) disable iff (reset)
      esc_pending_ff |-> in_frame_ff)
      else $error("escape armed outside a frame");

   a_cut_then_open : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1:0] == KIND_CUT) |-> (!rsp_tlast && fill_ff >= CNT_W'(2)))
      else $error("cut marker without its opening delimiter");

   a_first_is_delim : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2]) |-> (rsp_tdata == START_DELIM && rsp_tlast &&
                                        rsp_tuser[1:0] == KIND_DATA))
      else $error("first_of_frame on a non-delimiter beat");

endmodule
